// ----- rtl/core/evr_pkg.sv -----
package evr_pkg;

  localparam int COORD_W   = 16;
  localparam int ANGLE_W   = 16;
  localparam int TRIG_ITER = 16;
  localparam int TRIG_STEPS = (TRIG_ITER > 32) ? 32 : TRIG_ITER;

  // CORDIC datapath width, Q2.30 plus headroom
  localparam int CW = 34;
  // unsaturated intermediate coordinate width
  localparam int INT_W = COORD_W + 4;
  // product / sum width in the plane rotation
  localparam int PW = INT_W + 17;

  localparam logic signed [CW-1:0] CORDIC_GAIN = CW'(652032874);

  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z
  } axis_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } cordic_lane_t;

  typedef struct packed {
    cordic_lane_t [2:0]          lane;
    logic [2:0]                  flip;
    logic signed [COORD_W-1:0]   vx;
    logic signed [COORD_W-1:0]   vy;
    logic signed [COORD_W-1:0]   vz;
  } cordic_item_t;

  typedef struct packed {
    logic signed [INT_W-1:0] x;
    logic signed [INT_W-1:0] y;
    logic signed [INT_W-1:0] z;
    logic signed [15:0]      sx;
    logic signed [15:0]      cx;
    logic signed [15:0]      sy;
    logic signed [15:0]      cy;
    logic signed [15:0]      sz;
    logic signed [15:0]      cz;
  } rot_item_t;

  function automatic logic signed [CW-1:0] atan_q(input logic [4:0] i);
    logic signed [CW-1:0] r;
    unique case (i)
      5'd0:  r = CW'(536870912);
      5'd1:  r = CW'(316933406);
      5'd2:  r = CW'(167458907);
      5'd3:  r = CW'(85004756);
      5'd4:  r = CW'(42667331);
      5'd5:  r = CW'(21354465);
      5'd6:  r = CW'(10679838);
      5'd7:  r = CW'(5340245);
      5'd8:  r = CW'(2670163);
      5'd9:  r = CW'(1335087);
      5'd10: r = CW'(667544);
      5'd11: r = CW'(333772);
      5'd12: r = CW'(166886);
      5'd13: r = CW'(83443);
      5'd14: r = CW'(41722);
      5'd15: r = CW'(20861);
      5'd16: r = CW'(10430);
      5'd17: r = CW'(5215);
      5'd18: r = CW'(2608);
      5'd19: r = CW'(1304);
      5'd20: r = CW'(652);
      5'd21: r = CW'(326);
      5'd22: r = CW'(163);
      5'd23: r = CW'(81);
      5'd24: r = CW'(41);
      5'd25: r = CW'(20);
      5'd26: r = CW'(10);
      5'd27: r = CW'(5);
      5'd28: r = CW'(3);
      5'd29: r = CW'(1);
      5'd30: r = CW'(1);
      default: r = '0;
    endcase
    return r;
  endfunction

  // Q2.30 -> Q1.15, undo half-turn fold, round half up, saturate
  function automatic logic signed [15:0] trig_q15(input logic signed [CW-1:0] v,
                                                  input logic flip);
    logic signed [CW-1:0] w;
    logic signed [CW-1:0] r;
    logic signed [15:0]   q;
    w = flip ? -v : v;
    r = (w + signed'(CW'(16384))) >>> 15;
    if (r > signed'(CW'(32767)))       q = 16'sh7fff;
    else if (r < -signed'(CW'(32768))) q = 16'sh8000;
    else                               q = r[15:0];
    return q;
  endfunction

endpackage

// ----- rtl/core/evr_in_if.sv -----
interface evr_in_if;
  import evr_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] vec_x;
  logic signed [COORD_W-1:0] vec_y;
  logic signed [COORD_W-1:0] vec_z;
  logic signed [ANGLE_W-1:0] angle_x;
  logic signed [ANGLE_W-1:0] angle_y;
  logic signed [ANGLE_W-1:0] angle_z;

  modport source (output valid, vec_x, vec_y, vec_z, angle_x, angle_y, angle_z,
                  input ready);
  modport sink (input valid, vec_x, vec_y, vec_z, angle_x, angle_y, angle_z,
                output ready);
endinterface

// ----- rtl/core/evr_out_if.sv -----
interface evr_out_if;
  import evr_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] out_x;
  logic signed [COORD_W-1:0] out_y;
  logic signed [COORD_W-1:0] out_z;

  modport source (output valid, out_x, out_y, out_z, input ready);
  modport sink (input valid, out_x, out_y, out_z, output ready);
endinterface

// ----- rtl/core/euler_vector_rotation.sv -----
// Rotates one signed vector by Rz*Ry*Rx (about X first, then Y, then Z) per
// request. Fully pipelined: a new request is taken every clock unless the
// pipeline is stalled. The pipeline is 16 CORDIC cells working the three
// angles side by side, one trig rounding stage, three plane rotations of two
// stages each and one output register. Results saturate to the signed
// coordinate range. When the output register holds an untaken result the
// whole pipeline stalls and ready drops.
module euler_vector_rotation (
  input logic      clk,
  input logic      rst,
  evr_in_if.sink   req,
  evr_out_if.source rsp
);
  import evr_pkg::*;

  logic en;
  assign en        = !rsp.valid || rsp.ready;
  assign req.ready = en;

  // angle preparation: fold second/third quadrant by half a turn
  cordic_item_t             c_in;
  logic [2:0][ANGLE_W-1:0]  ang;
  logic [2:0][31:0]         ph;

  assign ang[0] = req.angle_x;
  assign ang[1] = req.angle_y;
  assign ang[2] = req.angle_z;

  always_comb begin
    c_in.vx = req.vec_x;
    c_in.vy = req.vec_y;
    c_in.vz = req.vec_z;
    for (int l = 0; l < 3; l++) begin
      ph[l]        = 32'(ang[l]) << (32 - ANGLE_W);
      c_in.flip[l] = ph[l][31] ^ ph[l][30];
      ph[l][31]    = ph[l][31] ^ c_in.flip[l];
      c_in.lane[l].x = CORDIC_GAIN;
      c_in.lane[l].y = '0;
      c_in.lane[l].z = CW'(signed'(ph[l]));
    end
  end

  cordic_item_t [TRIG_STEPS:0] chain;
  logic [TRIG_STEPS:0]         chain_valid;

  assign chain[0]       = c_in;
  assign chain_valid[0] = req.valid;

  for (genvar i = 0; i < TRIG_STEPS; i++) begin : g_cordic
    evr_cordic_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .step    (5'(i)),
      .d_valid (chain_valid[i]),
      .d       (chain[i]),
      .q_valid (chain_valid[i+1]),
      .q       (chain[i+1])
    );
  end

  // trig rounding stage
  rot_item_t r0;
  logic      r0_valid;
  cordic_item_t ct;
  assign ct = chain[TRIG_STEPS];

  always_ff @(posedge clk) begin
    if (en) begin
      r0.x  <= INT_W'(ct.vx);
      r0.y  <= INT_W'(ct.vy);
      r0.z  <= INT_W'(ct.vz);
      r0.cx <= trig_q15(ct.lane[0].x, ct.flip[0]);
      r0.sx <= trig_q15(ct.lane[0].y, ct.flip[0]);
      r0.cy <= trig_q15(ct.lane[1].x, ct.flip[1]);
      r0.sy <= trig_q15(ct.lane[1].y, ct.flip[1]);
      r0.cz <= trig_q15(ct.lane[2].x, ct.flip[2]);
      r0.sz <= trig_q15(ct.lane[2].y, ct.flip[2]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r0_valid <= 1'b0;
    end else if (en) begin
      r0_valid <= chain_valid[TRIG_STEPS];
    end
  end

  rot_item_t r1, r2, r3;
  logic      r1_valid, r2_valid, r3_valid;

  evr_rot_cell u_rot_x (
    .clk(clk), .rst(rst), .en(en), .axis(AXIS_X),
    .d_valid(r0_valid), .d(r0), .q_valid(r1_valid), .q(r1)
  );
  evr_rot_cell u_rot_y (
    .clk(clk), .rst(rst), .en(en), .axis(AXIS_Y),
    .d_valid(r1_valid), .d(r1), .q_valid(r2_valid), .q(r2)
  );
  evr_rot_cell u_rot_z (
    .clk(clk), .rst(rst), .en(en), .axis(AXIS_Z),
    .d_valid(r2_valid), .d(r2), .q_valid(r3_valid), .q(r3)
  );

  function automatic logic signed [COORD_W-1:0] sat_c(input logic signed [INT_W-1:0] v);
    logic signed [INT_W-1:0] hi;
    logic signed [INT_W-1:0] lo;
    hi = INT_W'({1'b0, {(COORD_W-1){1'b1}}});
    lo = -hi - INT_W'(1);
    if (v > hi)      return hi[COORD_W-1:0];
    else if (v < lo) return lo[COORD_W-1:0];
    else             return v[COORD_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      rsp.out_x <= sat_c(r3.x);
      rsp.out_y <= sat_c(r3.y);
      rsp.out_z <= sat_c(r3.z);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (en) begin
      rsp.valid <= r3_valid;
    end
  end
endmodule

// ----- rtl/core/evr_cordic_cell.sv -----
module evr_cordic_cell (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic [4:0]            step,
  input  logic                  d_valid,
  input  evr_pkg::cordic_item_t d,
  output logic                  q_valid,
  output evr_pkg::cordic_item_t q
);
  import evr_pkg::*;

  cordic_item_t          q_next;
  logic signed [CW-1:0]  ang;

  assign ang = atan_q(step);

  always_comb begin
    q_next = d;
    for (int l = 0; l < 3; l++) begin
      if (!d.lane[l].z[CW-1]) begin
        q_next.lane[l].x = d.lane[l].x - (d.lane[l].y >>> step);
        q_next.lane[l].y = d.lane[l].y + (d.lane[l].x >>> step);
        q_next.lane[l].z = d.lane[l].z - ang;
      end else begin
        q_next.lane[l].x = d.lane[l].x + (d.lane[l].y >>> step);
        q_next.lane[l].y = d.lane[l].y - (d.lane[l].x >>> step);
        q_next.lane[l].z = d.lane[l].z + ang;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (en) begin
      q_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= q_next;
    end
  end
endmodule

// ----- rtl/core/evr_rot_cell.sv -----
module evr_rot_cell (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  evr_pkg::axis_t     axis,
  input  logic               d_valid,
  input  evr_pkg::rot_item_t d,
  output logic               q_valid,
  output evr_pkg::rot_item_t q
);
  import evr_pkg::*;

  logic signed [INT_W-1:0] a, b;
  logic signed [15:0]      s, c;
  logic signed [PW-1:0]    p0, p1, p2, p3;
  rot_item_t               item1;
  logic                    valid1;
  logic signed [PW-1:0]    sum_a, sum_b;
  logic signed [INT_W-1:0] na, nb;
  rot_item_t               q_next;

  always_comb begin
    unique case (axis)
      AXIS_X: begin a = d.y; b = d.z; s = d.sx; c = d.cx; end
      AXIS_Y: begin a = d.z; b = d.x; s = d.sy; c = d.cy; end
      AXIS_Z: begin a = d.x; b = d.y; s = d.sz; c = d.cz; end
      default: begin a = d.x; b = d.y; s = d.sz; c = d.cz; end
    endcase
  end

  // multiply stage
  always_ff @(posedge clk) begin
    if (en) begin
      p0    <= PW'(c) * PW'(a);
      p1    <= PW'(s) * PW'(b);
      p2    <= PW'(s) * PW'(a);
      p3    <= PW'(c) * PW'(b);
      item1 <= d;
    end
  end

  // sum and round half up back to coordinate scale
  always_comb begin
    sum_a  = p0 - p1;
    sum_b  = p2 + p3;
    na     = INT_W'((sum_a + signed'(PW'(16384))) >>> 15);
    nb     = INT_W'((sum_b + signed'(PW'(16384))) >>> 15);
    q_next = item1;
    unique case (axis)
      AXIS_X: begin q_next.y = na; q_next.z = nb; end
      AXIS_Y: begin q_next.z = na; q_next.x = nb; end
      AXIS_Z: begin q_next.x = na; q_next.y = nb; end
      default: begin q_next.x = na; q_next.y = nb; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= q_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1  <= 1'b0;
      q_valid <= 1'b0;
    end else if (en) begin
      valid1  <= d_valid;
      q_valid <= valid1;
    end
  end
endmodule

// ----- rtl/core/evr_check.sv -----
module evr_check (
  input logic clk,
  input logic rst,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [evr_pkg::COORD_W-1:0] out_x,
  input logic [evr_pkg::COORD_W-1:0] out_y,
  input logic [evr_pkg::COORD_W-1:0] out_z
);
  import evr_pkg::*;

  a_no_valid_after_reset: assert property (@(posedge clk)
    rst |=> !out_valid) else $error("result valid right after reset");

  a_ready_follows_output: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready)) else $error("ready not tied to output slot");

  a_valid_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped while stalled");

  a_payload_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_x) && $stable(out_y) && $stable(out_z))
    else $error("stalled result changed");
endmodule

bind euler_vector_rotation evr_check u_evr_check (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (req.ready),
  .out_valid (rsp.valid),
  .out_ready (rsp.ready),
  .out_x     (rsp.out_x),
  .out_y     (rsp.out_y),
  .out_z     (rsp.out_z)
);
